>>> hdl/shtre_pkg.sv
// ----------------------------------------------------------------------------
// shtre_pkg
// Shared types and constants of the shadow tag range engine.
// ----------------------------------------------------------------------------
package shtre_pkg;

	localparam int ADDR_W      = 15;
	localparam int COUNT_W     = 16;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int FGRAN_W     = 12;
	localparam int TAG_W       = 8;
	// start granule fits in the address less its shortest possible offset (shift >= 1)
	localparam int START_W     = ADDR_W - 1;
	localparam int TOUCH_W     = COUNT_W;
	localparam int SUM_W       = COUNT_W + 1;
	localparam int QUEUE_DEPTH = 2;

	localparam int GRANULES_DEF      = 4096;
	localparam int GRANULE_SHIFT_DEF = 3;

	localparam logic [TAG_W-1:0] TAG_POISON = 8'hFF;
	localparam logic [TAG_W-1:0] TAG_OPEN   = 8'h00;

	typedef enum logic [OP_W-1:0] {
		OP_UNPOISON = 2'd0,
		OP_POISON   = 2'd1,
		OP_CLEAN    = 2'd2,
		OP_VALIDATE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_MISALIGN = 2'd1,
		ST_BADTAG   = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_WALK  = 2'd2
	} bk_state_t;

	// classified item handed from the front to the back
	typedef struct packed {
		status_t              status;
		op_t                  op;
		logic [START_W-1:0]   start;
		logic [TOUCH_W-1:0]   touch;
		logic                 tail_en;
		logic [TAG_W-1:0]     tail;
	} cmd_t;

endpackage

>>> hdl/shtre_front.sv
// ----------------------------------------------------------------------------
// shtre_front
// Classifies an incoming item: alignment and range checks, granule split.
// ----------------------------------------------------------------------------
module shtre_front #(
	parameter int GRANULES      = shtre_pkg::GRANULES_DEF,
	parameter int GRANULE_SHIFT = shtre_pkg::GRANULE_SHIFT_DEF
) (
	input  logic [shtre_pkg::OP_W-1:0]    operation,
	input  logic [shtre_pkg::ADDR_W-1:0]  byte_address,
	input  logic [shtre_pkg::COUNT_W-1:0] byte_count,
	output shtre_pkg::cmd_t               cmd
);
	import shtre_pkg::*;

	localparam int GMASK = (1 << GRANULE_SHIFT) - 1;

	op_t                op;
	logic               misalign;
	logic               range_err;
	logic [START_W-1:0] start;
	logic [TOUCH_W-1:0] full;
	logic [TAG_W-1:0]   tail;
	logic               tail_en;
	logic [TOUCH_W-1:0] touch;
	logic [SUM_W-1:0]   span_end;

	always_comb begin
		op        = op_t'(operation);
		misalign  = (byte_address & ADDR_W'(GMASK)) != '0;
		start     = START_W'(byte_address >> GRANULE_SHIFT);
		full      = byte_count >> GRANULE_SHIFT;
		tail      = TAG_W'(byte_count & COUNT_W'(GMASK));
		tail_en   = (tail != '0) && (op != OP_VALIDATE);
		touch     = full + TOUCH_W'(tail_en);
		span_end  = SUM_W'(start) + SUM_W'(touch);
		range_err = 32'(span_end) > 32'(GRANULES);

		cmd.op      = op;
		cmd.start   = start;
		cmd.touch   = touch;
		cmd.tail_en = tail_en;
		cmd.tail    = tail;
		priority if (misalign) begin
			cmd.status = ST_MISALIGN;
		end else if (range_err) begin
			cmd.status = ST_RANGE;
		end else begin
			cmd.status = ST_OK;
		end
	end

endmodule

>>> hdl/shtre_queue.sv
// ----------------------------------------------------------------------------
// shtre_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module shtre_queue #(
	parameter int DEPTH = shtre_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  shtre_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output shtre_pkg::cmd_t head
);
	import shtre_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hdl/shtre_back.sv
// ----------------------------------------------------------------------------
// shtre_back
// Tag store and granule walker: clears the store after reset, then walks
// each item one granule per cycle with a registered read and a checked write.
// ----------------------------------------------------------------------------
module shtre_back #(
	parameter int GRANULES = shtre_pkg::GRANULES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_not_empty,
	input  shtre_pkg::cmd_t                q_head,
	output logic                           q_pop,
	output logic                           store_ready,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [shtre_pkg::STATUS_W-1:0] status,
	output logic [shtre_pkg::FGRAN_W-1:0]  fault_granule,
	output logic [shtre_pkg::TAG_W-1:0]    fault_tag
);
	import shtre_pkg::*;

	localparam int GW = $clog2(GRANULES);

	logic [TAG_W-1:0] mem [GRANULES];

	bk_state_t          state_q, state_d;
	logic [GW-1:0]      clr_q;
	logic [SUM_W-1:0]   cur_q;
	logic [TOUCH_W-1:0] rem_q;
	op_t                op_q;
	logic               tail_en_q;
	logic [TAG_W-1:0]   tail_q;

	logic               vld_s1;
	logic [SUM_W-1:0]   g_s1;
	logic               tailk_s1;
	logic               last_s1;
	logic [TAG_W-1:0]   rd_data_s1;

	logic               out_valid_q;
	status_t            status_q;
	logic [FGRAN_W-1:0] fault_granule_q;
	logic [TAG_W-1:0]   fault_tag_q;

	logic               start_walk;
	logic               issue;
	logic               check;
	logic [TAG_W-1:0]   expect_tag;
	logic               mismatch;
	logic [TAG_W-1:0]   new_tag;
	logic               mem_we;
	logic [GW-1:0]      mem_wa;
	logic [TAG_W-1:0]   mem_wd;
	logic               load;
	status_t            ld_status;
	logic               ld_fault;

	// tag check and new tag for the granule whose read data is back
	always_comb begin
		check      = 1'b1;
		expect_tag = TAG_OPEN;
		new_tag    = tailk_s1 ? tail_q : TAG_OPEN;
		unique case (op_q)
			OP_UNPOISON: expect_tag = TAG_POISON;
			OP_POISON: begin
				expect_tag = tailk_s1 ? tail_q : TAG_OPEN;
				new_tag    = TAG_POISON;
			end
			OP_CLEAN:    check = 1'b0;
			OP_VALIDATE: expect_tag = TAG_OPEN;
			default:     check = 1'b0;
		endcase
		mismatch = check && (rd_data_s1 != expect_tag);
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		start_walk = 1'b0;
		issue      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = GW'(g_s1);
		mem_wd     = new_tag;
		load       = 1'b0;
		ld_status  = ST_OK;
		ld_fault   = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = TAG_POISON;
				if (clr_q == GW'(GRANULES - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_not_empty && !out_valid_q) begin
					q_pop = 1'b1;
					if (q_head.status != ST_OK) begin
						load      = 1'b1;
						ld_status = q_head.status;
					end else if (q_head.touch == '0) begin
						load = 1'b1;
					end else begin
						start_walk = 1'b1;
						state_d    = BK_WALK;
					end
				end
			end
			BK_WALK: begin
				issue = (rem_q != '0) && !(vld_s1 && (mismatch || last_s1));
				if (vld_s1) begin
					if (mismatch) begin
						load      = 1'b1;
						ld_status = ST_BADTAG;
						ld_fault  = 1'b1;
						state_d   = BK_IDLE;
					end else begin
						mem_we = op_q != OP_VALIDATE;
						if (last_s1) begin
							load    = 1'b1;
							state_d = BK_IDLE;
						end
					end
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	assign store_ready = state_q != BK_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			vld_s1 <= issue;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk registers and result payload
	always_ff @(posedge clk) begin
		if (start_walk) begin
			cur_q     <= SUM_W'(q_head.start);
			rem_q     <= q_head.touch;
			op_q      <= q_head.op;
			tail_en_q <= q_head.tail_en;
			tail_q    <= q_head.tail;
		end else if (issue) begin
			cur_q <= cur_q + 1'b1;
			rem_q <= rem_q - 1'b1;
		end
		if (issue) begin
			g_s1     <= cur_q;
			last_s1  <= rem_q == TOUCH_W'(1);
			tailk_s1 <= tail_en_q && (rem_q == TOUCH_W'(1));
		end
		if (load) begin
			status_q        <= ld_status;
			fault_granule_q <= ld_fault ? FGRAN_W'(g_s1) : '0;
			fault_tag_q     <= ld_fault ? rd_data_s1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rd_data_s1 <= mem[GW'(cur_q)];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign fault_granule = fault_granule_q;
	assign fault_tag     = fault_tag_q;

endmodule

>>> hdl/shadow_tag_range_engine_unit.sv
// ----------------------------------------------------------------------------
// shadow_tag_range_engine_unit
// Shadow tag store with range unpoison, poison, clean and validate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: operation, byte_address,
//   byte_count. Output channel (out_valid/out_ready) returns exactly one
//   result per item, in order: status, fault_granule, fault_tag.
//   After reset the tag store is swept to poisoned, one granule a cycle, and
//   in_ready stays low until the sweep has covered all GRANULES granules.
//   An item is classified on entry and placed in a two-entry queue. The
//   walker then reads and writes one granule per cycle through the store's
//   read port and write port; misaligned, out-of-range and empty items get
//   their result without a walk. A walk stops at the first bad tag.
//   The walker starts the next item only after the pending result has been
//   taken; while out_ready is low the queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module shadow_tag_range_engine_unit #(
	parameter int GRANULES      = shtre_pkg::GRANULES_DEF,
	parameter int GRANULE_SHIFT = shtre_pkg::GRANULE_SHIFT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [shtre_pkg::OP_W-1:0]     operation,
	input  logic [shtre_pkg::ADDR_W-1:0]   byte_address,
	input  logic [shtre_pkg::COUNT_W-1:0]  byte_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [shtre_pkg::STATUS_W-1:0] status,
	output logic [shtre_pkg::FGRAN_W-1:0]  fault_granule,
	output logic [shtre_pkg::TAG_W-1:0]    fault_tag
);
	import shtre_pkg::*;

	cmd_t front_cmd;
	cmd_t q_head;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic store_ready;

	shtre_front #(
		.GRANULES      (GRANULES),
		.GRANULE_SHIFT (GRANULE_SHIFT)
	) u_front (
		.operation    (operation),
		.byte_address (byte_address),
		.byte_count   (byte_count),
		.cmd          (front_cmd)
	);

	shtre_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && in_ready),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	shtre_back #(
		.GRANULES (GRANULES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.store_ready   (store_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.fault_granule (fault_granule),
		.fault_tag     (fault_tag)
	);

	assign in_ready = !q_full && store_ready;

	// no item gets in while the store sweep is running
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> !in_ready)
		else $error("item accepted during store clear");

	// fault fields are only set on a bad tag result
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_BADTAG) |-> (fault_granule == '0 && fault_tag == '0))
		else $error("fault fields set on non-fault result");

	// a result is never shown while the store is still being cleared
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> !out_valid)
		else $error("result during store clear");

endmodule
